/* rtl/core/reduction_combine_unit_top_assert.svh */
// Assertion macros for the reduction combine unit checker.
// Depends on a clk and rst signal in the scope where the macros are used.
`ifndef REDUCTION_COMBINE_UNIT_TOP_ASSERT_SVH
`define REDUCTION_COMBINE_UNIT_TOP_ASSERT_SVH

// Implication checked on every rising edge outside reset
`define RCU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcu checker: implication failed");

// Condition that must hold on every rising edge, reset included
`define RCU_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) (expr)) \
    else $error("rcu checker: invariant failed");

`endif

/* rtl/core/rcu_pkg.sv */
// Package for the reduction combine unit: operation codes, type encodings,
// register indexes and width helper functions. No dependencies.
`default_nettype none

package rcu_pkg;

  localparam int unsigned DataWidthDefault = 64;

  // Operation codes; 14 and 15 behave as no-op
  typedef enum logic [3:0] {
    OP_MAX     = 4'd0,
    OP_MIN     = 4'd1,
    OP_SUM     = 4'd2,
    OP_PROD    = 4'd3,
    OP_LAND    = 4'd4,
    OP_BAND    = 4'd5,
    OP_LOR     = 4'd6,
    OP_BOR     = 4'd7,
    OP_LXOR    = 4'd8,
    OP_BXOR    = 4'd9,
    OP_MAXLOC  = 4'd10,
    OP_MINLOC  = 4'd11,
    OP_REPLACE = 4'd12,
    OP_NOOP    = 4'd13
  } op_t;

  // Integer type: bits [2:1] pick 8/16/32/64, bit 0 set for signed
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_S32 = 3'd5;

  // Configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_OPERATION     = 2'd0;
  localparam reg_idx_t REG_ELEMENT_KIND  = 2'd1;
  localparam reg_idx_t REG_LOCATION_KIND = 2'd2;

  // Width in bits of a type, capped at the datapath width
  function automatic logic [6:0] kind_width(kind_t k, int unsigned cap);
    logic [6:0] w;
    w = 7'd8 << k[2:1];
    if (32'(w) > cap) begin
      w = 7'(cap);
    end
    return w;
  endfunction

  // Mask of the low w bits
  function automatic logic [63:0] width_mask(logic [6:0] w);
    logic [63:0] m;
    for (int i = 0; i < 64; i++) begin
      m[i] = (7'(i) < w);
    end
    return m;
  endfunction

  // Sign bit of a w-bit type, zero for unsigned types
  function automatic logic [63:0] sign_flip(logic [6:0] w, logic sgn);
    logic [63:0] m;
    for (int i = 0; i < 64; i++) begin
      m[i] = sgn && (7'(i) == w - 7'd1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/reduction_combine_unit_top.sv */
// Reduction combine unit top level: config registers and three-stage datapath.
// Depends on rcu_pkg.
`default_nettype none

// Takes one item in every cycle and gives its result on result_valid after the
// input register, the compare/partial-product stage and the result register.
// The 64-bit wrapping product is split into three half-width partial products,
// which sets the depth. The receiver cannot stall the unit; busy is high only
// during reset. Configuration must only be written while no item is in flight.
module reduction_combine_unit_top
  import rcu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  // item input
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] incoming_value,
  input  wire logic [63:0] accumulated_value,
  input  wire logic [63:0] incoming_location,
  input  wire logic [63:0] accumulated_location,
  input  wire logic        last_element,
  // result output
  output logic             result_valid,
  output logic [63:0]      combined_value,
  output logic [63:0]      combined_location,
  output logic             last_out
);

  localparam int unsigned LoW = (DATA_WIDTH + 1) / 2;
  localparam int unsigned HiW = DATA_WIDTH - LoW;

  // Configuration registers
  op_t   operation;
  kind_t element_kind;
  kind_t location_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation     <= OP_MAX;
      element_kind  <= KIND_S32;
      location_kind <= KIND_S32;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPERATION:     operation     <= op_t'(cfg_data);
        REG_ELEMENT_KIND:  element_kind  <= cfg_data[2:0];
        REG_LOCATION_KIND: location_kind <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Masks and sign bits derived from the type registers
  logic [6:0]            val_w, loc_w;
  logic [63:0]           val_mask64, loc_mask64, val_flip64, loc_flip64;
  logic [DATA_WIDTH-1:0] val_mask, loc_mask, val_flip, loc_flip;

  always_comb begin
    val_w      = kind_width(element_kind, DATA_WIDTH);
    loc_w      = kind_width(location_kind, DATA_WIDTH);
    val_mask64 = width_mask(val_w);
    loc_mask64 = width_mask(loc_w);
    val_flip64 = sign_flip(val_w, element_kind[0]);
    loc_flip64 = sign_flip(loc_w, location_kind[0]);
  end

  assign val_mask = val_mask64[DATA_WIDTH-1:0];
  assign loc_mask = loc_mask64[DATA_WIDTH-1:0];
  assign val_flip = val_flip64[DATA_WIDTH-1:0];
  assign loc_flip = loc_flip64[DATA_WIDTH-1:0];

  assign busy = rst;

  // Stage 1: input register, operands masked to their type widths
  logic                  s1_valid, s1_last;
  logic [DATA_WIDTH-1:0] s1_a, s1_b, s1_la, s1_lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_a    <= incoming_value[DATA_WIDTH-1:0] & val_mask;
    s1_b    <= accumulated_value[DATA_WIDTH-1:0] & val_mask;
    s1_la   <= incoming_location[DATA_WIDTH-1:0] & loc_mask;
    s1_lb   <= accumulated_location[DATA_WIDTH-1:0] & loc_mask;
    s1_last <= last_element;
  end

  // Stage 2: compares, selection and partial products
  logic                  a_gt_b, b_gt_a, lb_gt_la, a_nz, b_nz;
  logic [DATA_WIDTH-1:0] v_sel, loc_sel;
  logic [LoW-1:0]        a_lo, b_lo;
  logic [HiW-1:0]        a_hi, b_hi;
  logic [2*LoW-1:0]      pp_ll;
  logic [HiW-1:0]        pp_lh, pp_hl;

  assign a_gt_b   = (s1_a ^ val_flip) > (s1_b ^ val_flip);
  assign b_gt_a   = (s1_b ^ val_flip) > (s1_a ^ val_flip);
  assign lb_gt_la = (s1_lb ^ loc_flip) > (s1_la ^ loc_flip);
  assign a_nz     = |s1_a;
  assign b_nz     = |s1_b;

  assign a_lo = s1_a[LoW-1:0];
  assign b_lo = s1_b[LoW-1:0];
  assign a_hi = s1_a[DATA_WIDTH-1:LoW];
  assign b_hi = s1_b[DATA_WIDTH-1:LoW];

  // cross products only feed the upper half, so their low half is enough
  assign pp_ll = (2*LoW)'(a_lo) * (2*LoW)'(b_lo);
  assign pp_lh = HiW'(a_lo) * b_hi;
  assign pp_hl = a_hi * HiW'(b_lo);

  always_comb begin
    v_sel   = s1_b;
    loc_sel = s1_lb;
    case (operation)
      OP_MAX:     v_sel = a_gt_b ? s1_a : s1_b;
      OP_MIN:     v_sel = b_gt_a ? s1_a : s1_b;
      OP_SUM:     v_sel = s1_a + s1_b;
      OP_PROD:    v_sel = '0;
      OP_LAND:    v_sel = DATA_WIDTH'(a_nz && b_nz);
      OP_BAND:    v_sel = s1_a & s1_b;
      OP_LOR:     v_sel = DATA_WIDTH'(a_nz || b_nz);
      OP_BOR:     v_sel = s1_a | s1_b;
      OP_LXOR:    v_sel = DATA_WIDTH'(a_nz != b_nz);
      OP_BXOR:    v_sel = s1_a ^ s1_b;
      OP_MAXLOC, OP_MINLOC: begin
        if (s1_a == s1_b) begin
          // tie: keep value, smaller location wins
          loc_sel = lb_gt_la ? s1_la : s1_lb;
        end else if ((operation == OP_MAXLOC) ? a_gt_b : b_gt_a) begin
          v_sel   = s1_a;
          loc_sel = s1_la;
        end
      end
      OP_REPLACE: v_sel = s1_a;
      default:    v_sel = s1_b;
    endcase
  end

  logic                  s2_valid, s2_last, s2_is_prod;
  logic [DATA_WIDTH-1:0] s2_v, s2_loc;
  logic [2*LoW-1:0]      s2_ll;
  logic [HiW-1:0]        s2_lh, s2_hl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_last    <= s1_last;
    s2_is_prod <= (operation == OP_PROD);
    s2_v       <= v_sel;
    s2_loc     <= loc_sel;
    s2_ll      <= pp_ll;
    s2_lh      <= pp_lh;
    s2_hl      <= pp_hl;
  end

  // Stage 3: product assembly and result register
  logic [DATA_WIDTH-1:0] prod;
  logic [HiW-1:0]        cross_sum;
  logic [DATA_WIDTH-1:0] v_final;

  assign cross_sum = s2_lh + s2_hl;
  assign prod      = DATA_WIDTH'(s2_ll) + {cross_sum, {LoW{1'b0}}};
  assign v_final   = (s2_is_prod ? prod : s2_v) & val_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s2_valid;
    end
    combined_value    <= 64'(v_final);
    combined_location <= 64'(s2_loc);
    last_out          <= s2_last;
  end

endmodule

`default_nettype wire

/* rtl/core/rcu_checker.sv */
// Port-level checker for the reduction combine unit, bound to the top level.
// Depends on reduction_combine_unit_top_assert.svh.
`default_nettype none

`include "reduction_combine_unit_top_assert.svh"

module rcu_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic last_element,
  input wire logic result_valid,
  input wire logic last_out
);

  logic [2:0] rst_hist;
  logic       quiet3;

  // reset history in a three-bit shift register; quiet once all its bits are clear
  always_ff @(posedge clk) begin
    rst_hist <= {rst_hist[1:0], rst};
  end

  assign quiet3 = ~|rst_hist;

  // busy only ever reflects reset
  `RCU_ASSERT_ALWAYS(a_busy_is_reset, busy == rst)
  // every accepted item gives exactly one result, through the input, compare and result registers
  `RCU_ASSERT_IMPL(a_result_latency, quiet3, result_valid == $past(start && !busy, 3))
  // the last marker travels with its item
  `RCU_ASSERT_IMPL(a_last_follows, quiet3 && result_valid, last_out == $past(last_element, 3))
  // no result straight out of reset
  `RCU_ASSERT_IMPL(a_no_result_after_reset, $past(rst), !result_valid)

endmodule

bind reduction_combine_unit_top rcu_checker u_rcu_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .last_element (last_element),
  .result_valid (result_valid),
  .last_out     (last_out)
);

`default_nettype wire
